### src/cumulative_weight_sampler_table_defines.svh
// assertion macros for the weighted-selection table
// expects clk_i and rst_ni in the scope of each use
`ifndef CUMULATIVE_WEIGHT_SAMPLER_TABLE_DEFINES_SVH
`define CUMULATIVE_WEIGHT_SAMPLER_TABLE_DEFINES_SVH

// same-cycle implication
`define CWST_ASSERT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CWST_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/cwst_pkg.sv
// shared types, constants and microcode table of the weighted-selection table
// no dependencies
`timescale 1ns / 1ps

package cwst_pkg;

  localparam int unsigned MaxSpeciesDef = 1024;
  localparam int unsigned TotalWidthDef = 32;
  localparam int unsigned CfgWidth      = 32;
  localparam int unsigned RawWidth      = 32;
  localparam int unsigned IdxWidth      = 32;
  localparam int unsigned IdWidth       = 11;
  localparam int unsigned RtWidth       = 32;
  localparam int unsigned PaddrWidth    = 3;
  localparam int unsigned PcWidth       = 4;

  localparam logic [CfgWidth-1:0] MaxAbundanceRst = 32'd1000000;

  // register index, taken from paddr[2]
  localparam logic REG_MAX_ABUNDANCE = 1'b0;

  localparam logic CMD_ADD  = 1'b0;
  localparam logic CMD_PICK = 1'b1;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_OVERFLOW = 2'd2,
    ST_BAD_PICK = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_LATCH,
    OP_CLAMP,
    OP_SUM,
    OP_ADD_END,
    OP_PINIT,
    OP_PREAD,
    OP_PUPD,
    OP_PFIN,
    OP_EMIT
  } op_e;

  typedef enum logic [2:0] {
    C_NEVER,
    C_ALWAYS,
    C_NOT_IN_VALID,
    C_IS_PICK,
    C_BAD,
    C_LO_GE_HI,
    C_OUT_FREE
  } cond_e;

  typedef logic [PcWidth-1:0] pc_t;

  localparam pc_t STEP_FETCH   = 4'd0;
  localparam pc_t STEP_CLAMP   = 4'd1;
  localparam pc_t STEP_SUM     = 4'd2;
  localparam pc_t STEP_ADD_END = 4'd3;
  localparam pc_t STEP_PINIT   = 4'd4;
  localparam pc_t STEP_PCHECK  = 4'd5;
  localparam pc_t STEP_PREAD   = 4'd6;
  localparam pc_t STEP_PUPD    = 4'd7;
  localparam pc_t STEP_PFIN    = 4'd8;
  localparam pc_t STEP_EMIT    = 4'd9;
  localparam pc_t STEP_STALL   = 4'd10;

  typedef struct packed {
    op_e   op;
    cond_e cond;
    pc_t   target;
  } uword_t;

  typedef struct packed {
    logic in_valid;
    logic is_pick;
    logic bad;
    logic lo_ge_hi;
    logic out_free;
  } flags_t;

  // control store: jump to target when cond holds, else fall through
  function automatic uword_t ucode_rom(input pc_t pc);
    uword_t w;
    begin
      unique case (pc)
        STEP_FETCH:   w = '{op: OP_LATCH,   cond: C_NOT_IN_VALID, target: STEP_FETCH};
        STEP_CLAMP:   w = '{op: OP_CLAMP,   cond: C_IS_PICK,      target: STEP_PINIT};
        STEP_SUM:     w = '{op: OP_SUM,     cond: C_NEVER,        target: STEP_FETCH};
        STEP_ADD_END: w = '{op: OP_ADD_END, cond: C_ALWAYS,       target: STEP_EMIT};
        STEP_PINIT:   w = '{op: OP_PINIT,   cond: C_NEVER,        target: STEP_FETCH};
        STEP_PCHECK:  w = '{op: OP_NOP,     cond: C_BAD,          target: STEP_EMIT};
        STEP_PREAD:   w = '{op: OP_PREAD,   cond: C_LO_GE_HI,     target: STEP_PFIN};
        STEP_PUPD:    w = '{op: OP_PUPD,    cond: C_ALWAYS,       target: STEP_PREAD};
        STEP_PFIN:    w = '{op: OP_PFIN,    cond: C_NEVER,        target: STEP_FETCH};
        STEP_EMIT:    w = '{op: OP_EMIT,    cond: C_OUT_FREE,     target: STEP_FETCH};
        STEP_STALL:   w = '{op: OP_NOP,     cond: C_ALWAYS,       target: STEP_EMIT};
        default:      w = '{op: OP_NOP,     cond: C_ALWAYS,       target: STEP_FETCH};
      endcase
      return w;
    end
  endfunction

  // upper clamp first, then lower clamp to one
  function automatic logic [RawWidth-1:0] clamp_abundance(input logic [RawWidth-1:0] raw,
                                                          input logic [CfgWidth-1:0] lim);
    logic [RawWidth-1:0] amt;
    begin
      amt = (raw > lim) ? lim : raw;
      if (amt == '0) begin
        amt = RawWidth'(1);
      end
      return amt;
    end
  endfunction

endpackage

### src/cwst_if.sv
// request and result channels of the weighted-selection table
// depends on cwst_pkg
`timescale 1ns / 1ps

interface cwst_req_if import cwst_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                command;
  logic [RawWidth-1:0] raw_abundance;
  logic [IdxWidth-1:0] individual_index;

  modport source (output valid, command, raw_abundance, individual_index, input ready);
  modport sink   (input valid, command, raw_abundance, individual_index, output ready);
endinterface

interface cwst_rsp_if import cwst_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [IdWidth-1:0] species_id;
  logic [RtWidth-1:0] running_total;
  logic [1:0]         status;

  modport source (output valid, species_id, running_total, status, input ready);
  modport sink   (input valid, species_id, running_total, status, output ready);
endinterface

### src/cwst_ram.sv
// generic single-port ram with registered read
// no dependencies
`timescale 1ns / 1ps

module cwst_ram #(
  parameter int unsigned Width     = 32,
  parameter int unsigned Depth     = 1024,
  parameter int unsigned AddrWidth = $clog2(Depth)
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic                 re_i,
  input  logic [AddrWidth-1:0] addr_i,
  input  logic [Width-1:0]     wdata_i,
  output logic [Width-1:0]     rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### src/cwst_seq.sv
// microcode sequencer: step counter, control store and jump logic
// depends on cwst_pkg
`timescale 1ns / 1ps

module cwst_seq import cwst_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  flags_t flags_i,
  output op_e    op_o
);

  pc_t    pc_q, pc_d;
  uword_t uw;
  logic   take;

  always_comb begin
    uw = ucode_rom(pc_q);
    unique case (uw.cond)
      C_NEVER:        take = 1'b0;
      C_ALWAYS:       take = 1'b1;
      C_NOT_IN_VALID: take = !flags_i.in_valid;
      C_IS_PICK:      take = flags_i.is_pick;
      C_BAD:          take = flags_i.bad;
      C_LO_GE_HI:     take = flags_i.lo_ge_hi;
      C_OUT_FREE:     take = flags_i.out_free;
      default:        take = 1'b1;
    endcase
    pc_d = take ? uw.target : pc_q + 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= STEP_FETCH;
    end else begin
      pc_q <= pc_d;
    end
  end

  assign op_o = uw.op;

endmodule

### src/cwst_dp.sv
// datapath: request latch, clamp and sum, search window, result and output register
// depends on cwst_pkg and the assertion macros
`timescale 1ns / 1ps
`include "cumulative_weight_sampler_table_defines.svh"

module cwst_dp import cwst_pkg::*; #(
  parameter int unsigned MaxSpecies = MaxSpeciesDef,
  parameter int unsigned TotalWidth = TotalWidthDef,
  parameter int unsigned AddrWidth  = $clog2(MaxSpecies)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  op_e                   op_i,
  output flags_t                flags_o,
  input  logic [CfgWidth-1:0]   max_abundance_i,
  input  logic                  in_valid_i,
  input  logic                  command_i,
  input  logic [RawWidth-1:0]   raw_abundance_i,
  input  logic [IdxWidth-1:0]   individual_index_i,
  input  logic                  out_ready_i,
  output logic                  out_valid_o,
  output logic [IdWidth-1:0]    species_id_o,
  output logic [RtWidth-1:0]    running_total_o,
  output logic [1:0]            status_o,
  output logic                  ram_we_o,
  output logic                  ram_re_o,
  output logic [AddrWidth-1:0]  ram_addr_o,
  output logic [TotalWidth-1:0] ram_wdata_o,
  input  logic [TotalWidth-1:0] ram_rdata_i
);

  localparam int unsigned CntWidth = $clog2(MaxSpecies + 1);
  localparam int unsigned SumWidth = ((TotalWidth > RawWidth) ? TotalWidth : RawWidth) + 1;
  localparam int unsigned CmpWidth = (TotalWidth > IdxWidth) ? TotalWidth : IdxWidth;

  logic                  cmd_q, cmd_d;
  logic [RawWidth-1:0]   raw_q, raw_d;
  logic [IdxWidth-1:0]   idx_q, idx_d;
  logic [RawWidth-1:0]   amount_q, amount_d;
  logic [SumWidth-1:0]   sum_q, sum_d;
  logic [TotalWidth-1:0] total_q, total_d;
  logic [CntWidth-1:0]   count_q, count_d;
  logic [CntWidth-1:0]   lo_q, lo_d, hi_q, hi_d, mid_q, mid_d, mid_c;
  logic                  bad_q, bad_d;
  logic [IdWidth-1:0]    res_id_q, res_id_d;
  status_e               res_st_q, res_st_d;
  logic                  out_valid_q, out_valid_d;
  logic [IdWidth-1:0]    out_id_q, out_id_d;
  logic [RtWidth-1:0]    out_rt_q, out_rt_d;
  status_e               out_st_q, out_st_d;
  logic                  full, ovf, out_free;

  assign mid_c    = lo_q + ((hi_q - lo_q) >> 1);
  assign full     = (count_q == CntWidth'(MaxSpecies));
  assign ovf      = |sum_q[SumWidth-1:TotalWidth];
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    cmd_d       = cmd_q;
    raw_d       = raw_q;
    idx_d       = idx_q;
    amount_d    = amount_q;
    sum_d       = sum_q;
    total_d     = total_q;
    count_d     = count_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    mid_d       = mid_q;
    bad_d       = bad_q;
    res_id_d    = res_id_q;
    res_st_d    = res_st_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_id_d    = out_id_q;
    out_rt_d    = out_rt_q;
    out_st_d    = out_st_q;
    ram_we_o    = 1'b0;
    ram_re_o    = 1'b0;
    unique case (op_i)
      OP_NOP: begin
      end
      OP_LATCH: begin
        if (in_valid_i) begin
          cmd_d = command_i;
          raw_d = raw_abundance_i;
          idx_d = individual_index_i;
        end
      end
      OP_CLAMP: begin
        amount_d = clamp_abundance(raw_q, max_abundance_i);
      end
      OP_SUM: begin
        sum_d = SumWidth'(total_q) + SumWidth'(amount_q);
      end
      OP_ADD_END: begin
        if (full) begin
          res_id_d = '0;
          res_st_d = ST_FULL;
        end else if (ovf) begin
          res_id_d = '0;
          res_st_d = ST_OVERFLOW;
        end else begin
          ram_we_o = 1'b1;
          count_d  = count_q + 1'b1;
          total_d  = sum_q[TotalWidth-1:0];
          res_id_d = IdWidth'(count_q + 1'b1);
          res_st_d = ST_OK;
        end
      end
      OP_PINIT: begin
        lo_d     = '0;
        hi_d     = count_q;
        bad_d    = (count_q == '0) || (CmpWidth'(idx_q) >= CmpWidth'(total_q));
        res_id_d = '0;
        res_st_d = ST_BAD_PICK;
      end
      OP_PREAD: begin
        ram_re_o = 1'b1;
        mid_d    = mid_c;
      end
      OP_PUPD: begin
        if (CmpWidth'(ram_rdata_i) > CmpWidth'(idx_q)) begin
          hi_d = mid_q;
        end else begin
          lo_d = mid_q + 1'b1;
        end
      end
      OP_PFIN: begin
        if (lo_q < count_q) begin
          res_id_d = IdWidth'(lo_q + 1'b1);
          res_st_d = ST_OK;
        end
      end
      OP_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_id_d    = res_id_q;
          out_rt_d    = RtWidth'(total_q);
          out_st_d    = res_st_q;
        end
      end
      default: begin
      end
    endcase
  end

  assign ram_addr_o  = (op_i == OP_PREAD) ? mid_c[AddrWidth-1:0] : count_q[AddrWidth-1:0];
  assign ram_wdata_o = sum_q[TotalWidth-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q     <= '0;
      count_q     <= '0;
      lo_q        <= '0;
      hi_q        <= '0;
      bad_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      total_q     <= total_d;
      count_q     <= count_d;
      lo_q        <= lo_d;
      hi_q        <= hi_d;
      bad_q       <= bad_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q    <= cmd_d;
    raw_q    <= raw_d;
    idx_q    <= idx_d;
    amount_q <= amount_d;
    sum_q    <= sum_d;
    mid_q    <= mid_d;
    res_id_q <= res_id_d;
    res_st_q <= res_st_d;
    out_id_q <= out_id_d;
    out_rt_q <= out_rt_d;
    out_st_q <= out_st_d;
  end

  assign flags_o.in_valid = in_valid_i;
  assign flags_o.is_pick  = (cmd_q == CMD_PICK);
  assign flags_o.bad      = bad_q;
  assign flags_o.lo_ge_hi = (lo_q >= hi_q);
  assign flags_o.out_free = out_free;

  assign out_valid_o     = out_valid_q;
  assign species_id_o    = out_id_q;
  assign running_total_o = out_rt_q;
  assign status_o        = out_st_q;

  `CWST_ASSERT(a_count_bound, 1'b1, count_q <= CntWidth'(MaxSpecies), "species count past table size")
  `CWST_ASSERT_NEXT(a_add_commit, op_i == OP_ADD_END && !full && !ovf, count_q == $past(count_q) + 1'b1 && total_q > $past(total_q), "add did not grow table and total")
  `CWST_ASSERT(a_search_window, op_i == OP_PREAD || op_i == OP_PUPD, lo_q <= hi_q && hi_q <= count_q, "search window out of order")
  `CWST_ASSERT_NEXT(a_emit_load, op_i == OP_EMIT && out_free, out_valid_q && out_id_q == $past(res_id_q), "result not loaded on emit")

endmodule

### src/cumulative_weight_sampler_table.sv
// weighted-selection table over a prefix-sum store, with apb register port
// depends on cwst_pkg, cwst_if, cwst_ram, cwst_seq and cwst_dp
`timescale 1ns / 1ps

// req_i carries one request: command 0 adds a species with raw_abundance, clamped to
// 1..max_abundance, and appends the new running total; command 1 picks the species
// owning individual_index by binary search over the stored totals.
// rsp_o returns exactly one result per request: species_id (0 on error),
// running_total and status (ok, table full, total overflow, bad pick).
// a request is taken at a clock edge with valid and ready high; ready is high only
// in the fetch step of the microcode, so one request is in work at a time.
// an add runs the clamp, sum and add-end steps and then the emit step; a pick runs
// the clamp, init and check steps, and a rejected pick then goes to the emit step,
// while a searching pick first does one registered ram read and one compare per
// search step and a finish step. the next request can be taken in the cycle after
// the result enters the output register, so a new request waits for the last result;
// while the receiver stalls, a finished result waits in the emit and stall steps.
// reset empties the table and total and loads max_abundance with 1000000; the
// store itself is not cleared, only entries below the species count are read.
// max_abundance sits at byte address 0 of the apb port; pready is always high.

module cumulative_weight_sampler_table import cwst_pkg::*; #(
  parameter int unsigned MAX_SPECIES = MaxSpeciesDef,
  parameter int unsigned TOTAL_WIDTH = TotalWidthDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  cwst_req_if.sink              req_i,
  cwst_rsp_if.source            rsp_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [PaddrWidth-1:0] paddr,
  input  logic [CfgWidth-1:0]   pwdata,
  output logic [CfgWidth-1:0]   prdata,
  output logic                  pready
);

  localparam int unsigned AddrWidth = $clog2(MAX_SPECIES);

  logic [CfgWidth-1:0]    max_ab_q, max_ab_d;
  logic                   cfg_we;
  op_e                    op;
  flags_t                 flags;
  logic                   ram_we, ram_re;
  logic [AddrWidth-1:0]   ram_addr;
  logic [TOTAL_WIDTH-1:0] ram_wdata, ram_rdata;
  logic [1:0]             status;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && (paddr[2] == REG_MAX_ABUNDANCE);
  assign prdata = (paddr[2] == REG_MAX_ABUNDANCE) ? max_ab_q : '0;

  always_comb begin
    max_ab_d = max_ab_q;
    if (cfg_we) begin
      max_ab_d = pwdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_ab_q <= MaxAbundanceRst;
    end else begin
      max_ab_q <= max_ab_d;
    end
  end

  assign req_i.ready = (op == OP_LATCH);

  cwst_seq u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .flags_i (flags),
    .op_o    (op)
  );

  cwst_dp #(
    .MaxSpecies (MAX_SPECIES),
    .TotalWidth (TOTAL_WIDTH),
    .AddrWidth  (AddrWidth)
  ) u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .op_i               (op),
    .flags_o            (flags),
    .max_abundance_i    (max_ab_q),
    .in_valid_i         (req_i.valid),
    .command_i          (req_i.command),
    .raw_abundance_i    (req_i.raw_abundance),
    .individual_index_i (req_i.individual_index),
    .out_ready_i        (rsp_o.ready),
    .out_valid_o        (rsp_o.valid),
    .species_id_o       (rsp_o.species_id),
    .running_total_o    (rsp_o.running_total),
    .status_o           (status),
    .ram_we_o           (ram_we),
    .ram_re_o           (ram_re),
    .ram_addr_o         (ram_addr),
    .ram_wdata_o        (ram_wdata),
    .ram_rdata_i        (ram_rdata)
  );

  assign rsp_o.status = status;

  cwst_ram #(
    .Width     (TOTAL_WIDTH),
    .Depth     (MAX_SPECIES),
    .AddrWidth (AddrWidth)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .re_i    (ram_re),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

endmodule
